[src/xild_pkg.sv]
// Package: shared types, constants and decode functions for the length decoder.
`default_nettype none
package xild_pkg;

  localparam int unsigned FlagW = 11;
  localparam int unsigned LenW  = 4;
  localparam int unsigned QDepth = 2;

  localparam logic [FlagW-1:0] FlagOpsize   = 11'h200;
  localparam logic [FlagW-1:0] FlagAddrsize = 11'h400;

  // classified word handed from front to back
  typedef struct packed {
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic [7:0]       b3;
    logic             pfx;
    logic [FlagW-1:0] flags;
  } xild_item_t;

  typedef struct packed {
    logic [LenW-1:0]  length;
    logic             is_prefix;
    logic             invalid;
    logic [FlagW-1:0] prefixes_seen;
  } xild_res_t;

  function automatic logic [FlagW-1:0] prefix_bit(input logic [7:0] b);
    logic [FlagW-1:0] r;
    begin
      unique case (b)
        8'h26: r = 11'h001;
        8'h2E: r = 11'h002;
        8'h36: r = 11'h004;
        8'h3E: r = 11'h008;
        8'h64: r = 11'h010;
        8'h65: r = 11'h020;
        8'hF0: r = 11'h040;
        8'hF2: r = 11'h080;
        8'hF3: r = 11'h100;
        8'h66: r = FlagOpsize;
        8'h67: r = FlagAddrsize;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // ModRM + SIB + displacement bytes
  function automatic logic [3:0] modrm_bytes(input logic [7:0] m, input logic [7:0] sib,
                                             input logic a16);
    logic [1:0] md;
    logic [2:0] rm;
    logic [3:0] n;
    begin
      md = m[7:6];
      rm = m[2:0];
      n  = 4'd1;
      if (md != 2'd3) begin
        if (!a16 && rm == 3'd4) begin
          n = n + 4'd1;
          if (sib[2:0] == 3'd5 && md == 2'd0) n = n + 4'd4;
        end
        if (md == 2'd0) begin
          if (!a16 && rm == 3'd5) n = n + 4'd4;
          if (a16 && rm == 3'd6) n = n + 4'd2;
        end else if (md == 2'd1) begin
          n = n + 4'd1;
        end else begin
          n = n + (a16 ? 4'd2 : 4'd4);
        end
      end
      return n;
    end
  endfunction

  function automatic logic [3:0] decode_len(input logic [7:0] op, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [FlagW-1:0] flags);
    logic       a16;
    logic [3:0] opw, adw, mr, mr2;
    logic [2:0] lo, rg;
    logic [3:0] r;
    begin
      a16 = (flags & FlagAddrsize) != '0;
      opw = ((flags & FlagOpsize) != '0) ? 4'd2 : 4'd4;
      adw = a16 ? 4'd2 : 4'd4;
      lo  = op[2:0];
      rg  = b1[5:3];
      mr  = modrm_bytes(b1, b2, a16);
      mr2 = modrm_bytes(b2, b3, a16);
      r   = 4'd0;
      if (op == 8'h0F) begin
        if (b1 == 8'h06 || b1 == 8'h08 || b1 == 8'h09 || (b1 >= 8'h30 && b1 <= 8'h33) ||
            b1 == 8'hA0 || b1 == 8'hA1 || b1 == 8'hA8 || b1 == 8'hA9 || b1 >= 8'hC8 &&
            b1 <= 8'hCF)
          r = 4'd2;
        else if (b1 >= 8'h20 && b1 <= 8'h23)
          r = 4'd3;
        else if (b1 == 8'hA4 || b1 == 8'hAC || b1 == 8'hBA)
          r = 4'd3 + mr2;
        else if (b1 <= 8'h03 || b1 == 8'h0B || b1 == 8'h1F || (b1 >= 8'h40 && b1 <= 8'h47) ||
                 (b1 >= 8'h90 && b1 <= 8'h9F) || b1 == 8'hA3 || b1 == 8'hA5 ||
                 b1 == 8'hAA || b1 == 8'hAB || b1 == 8'hAD || b1 == 8'hAF ||
                 (b1 >= 8'hB0 && b1 <= 8'hB7) || (b1 >= 8'hBB && b1 <= 8'hBF) ||
                 b1 == 8'hC0 || b1 == 8'hC1 || b1 == 8'hC7)
          r = 4'd2 + mr2;
        else if (b1 >= 8'h80 && b1 <= 8'h8F)
          r = 4'd2 + opw;
      end else if (op < 8'h40) begin
        if (lo < 3'd4) r = 4'd1 + mr;
        else if (lo == 3'd4) r = 4'd2;
        else if (lo == 3'd5) r = 4'd1 + opw;
        else r = 4'd1;
      end else if (op <= 8'h61 || (op >= 8'h6C && op <= 8'h6F) ||
                   (op >= 8'h90 && op <= 8'h99) || (op >= 8'h9B && op <= 8'h9F) ||
                   (op >= 8'hA4 && op <= 8'hA7) || (op >= 8'hAA && op <= 8'hAF) ||
                   op == 8'hC3 || op == 8'hC9 || op == 8'hCB || op == 8'hCC ||
                   op == 8'hCE || op == 8'hCF || op == 8'hD6 || op == 8'hD7 ||
                   (op >= 8'hEC && op <= 8'hEF) || op == 8'hF4 || op == 8'hF5 ||
                   (op >= 8'hF8 && op <= 8'hFD)) begin
        r = 4'd1;
      end else if (op == 8'h6A || (op >= 8'h70 && op <= 8'h7F) || op == 8'hA8 ||
                   (op >= 8'hB0 && op <= 8'hB7) || op == 8'hCD || op == 8'hD4 ||
                   op == 8'hD5 || (op >= 8'hE0 && op <= 8'hE7) || op == 8'hEB) begin
        r = 4'd2;
      end else if (op == 8'hC2 || op == 8'hCA) begin
        r = 4'd3;
      end else if (op == 8'hC8) begin
        r = 4'd4;
      end else if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC6 ||
                   op == 8'h6B || op == 8'hC0 || op == 8'hC1) begin
        r = 4'd2 + mr;
      end else if (op == 8'h69 || op == 8'h81 || op == 8'hC7) begin
        r = 4'd1 + mr + opw;
      end else if (op == 8'h68 || op == 8'hA9 || (op >= 8'hB8 && op <= 8'hBF) ||
                   op == 8'hE8 || op == 8'hE9) begin
        r = 4'd1 + opw;
      end else if (op == 8'h9A || op == 8'hEA) begin
        r = 4'd3 + opw;
      end else if (op >= 8'hA0 && op <= 8'hA3) begin
        r = 4'd1 + adw;
      end else if ((op >= 8'hD8 && op <= 8'hDF) || op == 8'h62 || op == 8'h63 ||
                   (op >= 8'h84 && op <= 8'h8F) || op == 8'hC4 || op == 8'hC5 ||
                   (op >= 8'hD0 && op <= 8'hD3)) begin
        r = 4'd1 + mr;
      end else if (op == 8'hFE) begin
        r = (b1 >= 8'hD0) ? 4'd0 : 4'd1 + mr;
      end else if (op == 8'hFF) begin
        r = (b1 >= 8'hD8 && b1[3]) ? 4'd0 : 4'd1 + mr;
      end else if (op == 8'hF6) begin
        if (rg != 3'd1) r = 4'd1 + mr + ((rg == 3'd0) ? 4'd1 : 4'd0);
      end else if (op == 8'hF7) begin
        if (rg != 3'd1) r = 4'd1 + mr + ((rg == 3'd0) ? opw : 4'd0);
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

[src/xild_if.sv]
// Interfaces: input byte window channel and result channel.
`default_nettype none
interface xild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  modport source (output valid, first_byte, second_byte, third_byte, fourth_byte,
                  input ready);
  modport sink (input valid, first_byte, second_byte, third_byte, fourth_byte,
                output ready);
endinterface

interface xild_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  length;
  logic        is_prefix;
  logic        invalid;
  logic [10:0] prefixes_seen;
  modport source (output valid, length, is_prefix, invalid, prefixes_seen, input ready);
  modport sink (input valid, length, is_prefix, invalid, prefixes_seen, output ready);
endinterface
`default_nettype wire

[src/xild_front.sv]
// Front: accepts byte windows, tracks prefix flags, pushes classified words.
`default_nettype none
module xild_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [7:0]          in_b0,
  input  wire logic [7:0]          in_b1,
  input  wire logic [7:0]          in_b2,
  input  wire logic [7:0]          in_b3,
  output      logic                push,
  input  wire logic                q_full,
  output      xild_pkg::xild_item_t push_item
);
  logic [xild_pkg::FlagW-1:0] flags_r, flags_nxt, pbit;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign pbit     = xild_pkg::prefix_bit(in_b0);

  always_comb begin
    push_item.b0  = in_b0;
    push_item.b1  = in_b1;
    push_item.b2  = in_b2;
    push_item.b3  = in_b3;
    push_item.pfx = pbit != '0;
    push_item.flags = flags_r | pbit;
    flags_nxt = flags_r;
    if (push) flags_nxt = (pbit != '0) ? (flags_r | pbit) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) flags_r <= '0;
    else flags_r <= flags_nxt;
  end
endmodule
`default_nettype wire

[src/xild_queue.sv]
// Queue: short FIFO between front and back.
`default_nettype none
module xild_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire xild_pkg::xild_item_t push_item,
  output      logic                 full,
  input  wire logic                 pop,
  output      logic                 not_empty,
  output      xild_pkg::xild_item_t head
);
  localparam int unsigned AW = $clog2(xild_pkg::QDepth);
  xild_pkg::xild_item_t mem_r [xild_pkg::QDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full      = cnt_r == (AW+1)'(xild_pkg::QDepth);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[src/xild_back.sv]
// Back: decodes the length and holds the result in an output register.
`default_nettype none
module xild_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 not_empty,
  input  wire xild_pkg::xild_item_t head,
  output      logic                 pop,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      xild_pkg::xild_res_t  res
);
  logic                valid_r;
  xild_pkg::xild_res_t res_r, res_nxt;
  logic [3:0]          len;

  assign pop       = not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign res       = res_r;
  assign len = xild_pkg::decode_len(head.b0, head.b1, head.b2, head.b3, head.flags);

  always_comb begin
    res_nxt.prefixes_seen = head.flags;
    res_nxt.is_prefix     = head.pfx;
    res_nxt.length        = head.pfx ? 4'd1 : len;
    res_nxt.invalid       = !head.pfx && len == 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (pop) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end
endmodule
`default_nettype wire

[src/x86_instruction_length_decoder_unit.sv]
// Top level: IA-32 instruction length decoder.
// A result is first written into the queue and then loaded into the output register
// before it is offered on the result channel.
// Throughput: one word per cycle while the queue is not full; a two-entry queue decouples
// front from back. Back pressure holds in_ready low only once the queue is full.
// Reset (rst_n low, synchronous) clears prefix flags, queue and output valid.
`default_nettype none
module x86_instruction_length_decoder_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  xild_in_if.sink    in_ch,
  xild_out_if.source out_ch
);
  logic                 push, full, pop, not_empty, in_ready, out_valid;
  xild_pkg::xild_item_t push_item, head;
  xild_pkg::xild_res_t  res;

  xild_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready,
    .in_b0(in_ch.first_byte), .in_b1(in_ch.second_byte),
    .in_b2(in_ch.third_byte), .in_b3(in_ch.fourth_byte),
    .push, .q_full(full), .push_item
  );

  xild_queue u_queue (
    .clk, .rst_n, .push, .push_item, .full, .pop, .not_empty, .head
  );

  xild_back u_back (
    .clk, .rst_n, .not_empty, .head, .pop, .out_valid, .out_ready(out_ch.ready), .res
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.length        = res.length;
  assign out_ch.is_prefix     = res.is_prefix;
  assign out_ch.invalid       = res.invalid;
  assign out_ch.prefixes_seen = res.prefixes_seen;
endmodule
`default_nettype wire

[src/xild_checker.sv]
// Checker: port-level properties of the length decoder, bound to the top level.
`default_nettype none
module xild_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_length,
  input wire logic        out_is_prefix,
  input wire logic        out_invalid,
  input wire logic [10:0] out_prefixes_seen
);
  a_prefix_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_prefix |-> out_length == 4'd1 && !out_invalid && out_prefixes_seen != '0)
    else $error("prefix result malformed");
  a_invalid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_invalid == (out_length == 4'd0))
    else $error("invalid flag disagrees with length");
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length <= 4'd11)
    else $error("length out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_length))
    else $error("stalled result changed");
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind x86_instruction_length_decoder_unit xild_checker u_xild_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_length(out_ch.length),
  .out_is_prefix(out_ch.is_prefix), .out_invalid(out_ch.invalid),
  .out_prefixes_seen(out_ch.prefixes_seen)
);
`default_nettype wire

[sim/xild_checker.sv]
// Checker: watches both channels, predicts decoder results and compares them.
module tb_xild_checker (
  input  logic        clk,
  input  logic        rst_n,
  xild_in_if          in_ch,
  xild_out_if         out_ch,
  output int unsigned errors,
  output int unsigned pending
);
  typedef struct packed {
    logic [3:0]  length;
    logic        is_prefix;
    logic        invalid;
    logic [10:0] prefixes_seen;
  } expect_t;

  expect_t    results_q[$];
  logic [10:0] held_flags;

  function automatic logic [10:0] pfx_mask(input logic [7:0] b);
    case (b)
      8'h26: return 11'h001;
      8'h2E: return 11'h002;
      8'h36: return 11'h004;
      8'h3E: return 11'h008;
      8'h64: return 11'h010;
      8'h65: return 11'h020;
      8'hF0: return 11'h040;
      8'hF2: return 11'h080;
      8'hF3: return 11'h100;
      8'h66: return xild_pkg::FlagOpsize;
      8'h67: return xild_pkg::FlagAddrsize;
      default: return '0;
    endcase
  endfunction

  function automatic int addr_bytes(input logic [7:0] m, input logic [7:0] sib, input bit a16);
    int n;
    n = 1;
    if (m[7:6] == 2'd3) return n;
    if (!a16 && m[2:0] == 3'd4) begin
      n++;
      if (sib[2:0] == 3'd5 && m[7:6] == 2'd0) n += 4;
    end
    if (m[7:6] == 2'd0) begin
      if (!a16 && m[2:0] == 3'd5) n += 4;
      if (a16 && m[2:0] == 3'd6) n += 2;
    end else if (m[7:6] == 2'd1) n += 1;
    else n += a16 ? 2 : 4;
    return n;
  endfunction

  function automatic int insn_len(input logic [7:0] op, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [10:0] fl);
    bit a16;
    int opw, adw, mr, mr2;
    logic [2:0] rg;
    a16 = fl[10];
    opw = fl[9] ? 2 : 4;
    adw = a16 ? 2 : 4;
    rg  = b1[5:3];
    mr  = addr_bytes(b1, b2, a16);
    mr2 = addr_bytes(b2, b3, a16);
    if (op == 8'h0F) begin
      if (b1 inside {8'h06, 8'h08, 8'h09, [8'h30:8'h33], 8'hA0, 8'hA1, 8'hA8, 8'hA9,
                     [8'hC8:8'hCF]}) return 2;
      if (b1 inside {[8'h20:8'h23]}) return 3;
      if (b1 inside {8'hA4, 8'hAC, 8'hBA}) return 3 + mr2;
      if (b1 inside {[8'h00:8'h03], 8'h0B, 8'h1F, [8'h40:8'h47], [8'h90:8'h9F], 8'hA3,
                     8'hA5, 8'hAA, 8'hAB, 8'hAD, 8'hAF, [8'hB0:8'hB7], [8'hBB:8'hBF],
                     8'hC0, 8'hC1, 8'hC7}) return 2 + mr2;
      if (b1 inside {[8'h80:8'h8F]}) return 2 + opw;
      return 0;
    end
    if (op < 8'h40) begin
      if (op[2:0] < 3'd4) return 1 + mr;
      if (op[2:0] == 3'd4) return 2;
      if (op[2:0] == 3'd5) return 1 + opw;
      return 1;
    end
    if (op inside {[8'h40:8'h61], [8'h6C:8'h6F], [8'h90:8'h99], [8'h9B:8'h9F],
                   [8'hA4:8'hA7], [8'hAA:8'hAF], 8'hC3, 8'hC9, 8'hCB, 8'hCC, 8'hCE,
                   8'hCF, 8'hD6, 8'hD7, [8'hEC:8'hEF], 8'hF4, 8'hF5, [8'hF8:8'hFD]})
      return 1;
    if (op inside {8'h6A, [8'h70:8'h7F], 8'hA8, [8'hB0:8'hB7], 8'hCD, 8'hD4, 8'hD5,
                   [8'hE0:8'hE7], 8'hEB}) return 2;
    if (op inside {8'hC2, 8'hCA}) return 3;
    if (op == 8'hC8) return 4;
    if (op inside {8'h80, 8'h82, 8'h83, 8'hC6, 8'h6B, 8'hC0, 8'hC1}) return 2 + mr;
    if (op inside {8'h69, 8'h81, 8'hC7}) return 1 + mr + opw;
    if (op inside {8'h68, 8'hA9, [8'hB8:8'hBF], 8'hE8, 8'hE9}) return 1 + opw;
    if (op inside {8'h9A, 8'hEA}) return 3 + opw;
    if (op inside {[8'hA0:8'hA3]}) return 1 + adw;
    if (op inside {[8'hD8:8'hDF], 8'h62, 8'h63, [8'h84:8'h8F], 8'hC4, 8'hC5,
                   [8'hD0:8'hD3]}) return 1 + mr;
    if (op == 8'hFE) return (b1 >= 8'hD0) ? 0 : 1 + mr;
    if (op == 8'hFF) return (b1 >= 8'hD8 && b1[3]) ? 0 : 1 + mr;
    if (op == 8'hF6) return (rg == 3'd1) ? 0 : 1 + mr + (rg == 3'd0 ? 1 : 0);
    if (op == 8'hF7) return (rg == 3'd1) ? 0 : 1 + mr + (rg == 3'd0 ? opw : 0);
    return 0;
  endfunction

  always @(posedge clk) begin
    logic [10:0] bit_m;
    int          len;
    expect_t     want, got;
    if (!rst_n) begin
      held_flags <= '0;
      results_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.length, out_ch.is_prefix, out_ch.invalid, out_ch.prefixes_seen};
        if (results_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word %h", got);
        end else begin
          want = results_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp len %0d pfx %b inv %b seen %h, got %0d %b %b %h",
                       want.length, want.is_prefix, want.invalid, want.prefixes_seen,
                       got.length, got.is_prefix, got.invalid, got.prefixes_seen);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bit_m = pfx_mask(in_ch.first_byte);
        if (bit_m != '0) begin
          results_q.push_back({4'd1, 1'b1, 1'b0, held_flags | bit_m});
          held_flags <= held_flags | bit_m;
        end else begin
          len = insn_len(in_ch.first_byte, in_ch.second_byte, in_ch.third_byte,
                         in_ch.fourth_byte, held_flags);
          results_q.push_back({len[3:0], 1'b0, len == 0, held_flags});
          held_flags <= '0;
        end
      end
      pending <= results_q.size();
    end
  end
endmodule

[sim/tb_x86_instruction_length_decoder_unit.sv]
// Testbench top: drives byte windows, back pressure and gives the verdict.
module tb_x86_instruction_length_decoder_unit;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned errors, pending;
  int unsigned idle_cycles;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;
  int          hold_off = 0;

  xild_in_if  in_ch();
  xild_out_if out_ch();

  x86_instruction_length_decoder_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                           .out_ch(out_ch));
  tb_xild_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                       .errors(errors), .pending(pending));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam logic [7:0] PrefixBytes[11] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
                                             8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.first_byte = '0;
    in_ch.second_byte = '0;
    in_ch.third_byte = '0;
    in_ch.fourth_byte = '0;
  end

  // offer one word, hold until accepted; may idle first. valid stays high on return
  task automatic send_word(input logic [7:0] a, b, c, d, input bit may_idle);
    while (may_idle && !calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_byte <= a;
    in_ch.second_byte <= b;
    in_ch.third_byte <= c;
    in_ch.fourth_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic rand_insn();
    int k;
    logic [7:0] op;
    k = $urandom_range(3);
    repeat (k) send_word(PrefixBytes[$urandom_range(10)], 8'($urandom), 8'($urandom),
                         8'($urandom), 1);
    case ($urandom_range(3))
      0: op = 8'h0F;
      1: op = 8'hF6 + 8'($urandom_range(1));
      2: op = 8'hFE + 8'($urandom_range(1));
      default: op = 8'($urandom);
    endcase
    send_word(op, 8'($urandom), 8'($urandom), 8'($urandom), 1);
  endtask

  // receiver: random stalls, one long hold-off, calm stretch
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: extremes, prefix repeat, special cases
    send_word(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    send_word(8'h66, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'h66, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'h67, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'hC7, 8'h06, 8'h00, 8'h00, 0);
    send_word(8'hF1, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'h0F, 8'hFF, 8'h00, 8'h00, 0);
    send_word(8'hFE, 8'hD0, 8'h00, 8'h00, 0);
    send_word(8'hFF, 8'hD8, 8'h00, 8'h00, 0);
    send_word(8'hF6, 8'h08, 8'h00, 8'h00, 0);
    send_word(8'hF7, 8'h08, 8'h00, 8'h00, 0);
    send_word(8'h81, 8'h04, 8'h05, 8'h00, 0);
    send_word(8'h6B, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'h0F, 8'h22, 8'h00, 8'h00, 0);
    send_word(8'h0F, 8'hA4, 8'h84, 8'h05, 0);
    send_word(8'h66, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'hF7, 8'h80, 8'h00, 8'h00, 0);
    send_word(8'h67, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'h8B, 8'h06, 8'h00, 8'h00, 0);
    send_word(8'hF0, 8'h00, 8'h00, 8'h00, 0);
    send_word(8'hFF, 8'h55, 8'h00, 8'h00, 0);
    // long receiver hold-off while the sender keeps offering
    hold_off <= 60;
    repeat (10) rand_insn();
    repeat (300) rand_insn();
    calm = 1'b1;
    repeat (80) rand_insn();
    calm = 1'b0;
    repeat (130) rand_insn();
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0 && idle_cycles < 2000) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending == 0 && errors == 0) $display("tb_x86_instruction_length_decoder_unit OK");
    else $display("tb_x86_instruction_length_decoder_unit NOT OK");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 2000);
    $display("tb_x86_instruction_length_decoder_unit NOT OK");
    $finish;
  end
endmodule
